>>> rtl/core/murmur2_64_hash_assert.svh
// Assertion macros for the murmur2 64-bit hash engine.
`ifndef MURMUR2_64_HASH_ASSERT_SVH
`define MURMUR2_64_HASH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M2H_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("m2h check");
`define M2H_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("m2h reset check");
`else
`define M2H_ASSERT(label, clk, rst_n, prop)
`define M2H_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/core/m2h_pkg.sv
// Shared types and constants for the murmur2 64-bit hash engine.
package m2h_pkg;
    localparam logic [63:0] MIX64 = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX32 = 32'h5bd1e995;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  nbytes;
        logic [30:0] key_length;
        logic        last;
    } t_word;
endpackage

>>> rtl/core/m2h_front.sv
// Input stage: accept words, saturate byte count, push into a two-entry queue.
module m2h_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [63:0]    i_data_word,
    input  logic [3:0]     i_valid_bytes,
    input  logic [30:0]    i_key_length,
    input  logic           i_last,
    output logic           o_q_valid,
    output m2h_pkg::t_word o_q_word,
    input  logic           i_q_pop
);
    import m2h_pkg::*;

    t_word      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_word      w;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];

    always_comb begin
        w.data_word  = i_data_word;
        w.key_length = i_key_length;
        w.last       = i_last;
        // non-last words always mix as full blocks
        if (!i_last || i_valid_bytes > 4'd8) w.nbytes = 4'd8;
        else w.nbytes = i_valid_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= w;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    `include "murmur2_64_hash_assert.svh"
    `M2H_ASSERT(a_no_overflow, i_clk, i_rst_n, !(r_cnt == 2'd2 && push && !i_q_pop))
    `M2H_ASSERT(a_no_underflow, i_clk, i_rst_n, !(r_cnt == 2'd0 && i_q_pop))
    `M2H_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
endmodule

>>> rtl/core/m2h_back.sv
// Hash sequencer: one 32x32 multiplier shared by every mixing step.
module m2h_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [63:0]    i_seed,
    input  logic           i_variant,
    input  logic           i_q_valid,
    input  m2h_pkg::t_word i_q_word,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_hash_value
);
    import m2h_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_SEEDX, S_BLK, S_A_K1, S_A_K2, S_A_H, S_A_F2,
        S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_BT,
        S_FIN, S_F2, S_F3, S_F4, S_M0, S_M1, S_M2, S_OUT
    } t_state;

    t_state      r_st, r_ret;
    t_word       r_w;
    logic        r_b, r_in_key;
    logic [63:0] r_h, r_mx, r_mp;
    logic [31:0] r_k;
    logic [63:0] r_out;
    logic        r_ov;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_y;
    logic [63:0] low_mask;
    logic [31:0] tail32;
    logic [31:0] kmix;
    logic        out_load;

    // 32x32 product, full 64 bits
    assign mul_y = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        low_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {r_w.nbytes[2:0], 3'b000});
        tail32   = (r_w.nbytes[2] ? r_w.data_word[63:32] : r_w.data_word[31:0])
                   & ~(32'hFFFF_FFFF << {r_w.nbytes[1:0], 3'b000});
        kmix     = r_k ^ (r_k >> 24);
    end

    // multiplier operands per step; S_M0..S_M2 build a 64-bit product mod 2^64
    always_comb begin
        mul_a = '0;
        mul_b = MIX32;
        case (r_st)
            S_M0: begin
                mul_a = r_mx[31:0]; mul_b = MIX64[31:0];
            end
            S_M1: begin
                mul_a = r_mx[31:0]; mul_b = MIX64[63:32];
            end
            S_M2: begin
                mul_a = r_mx[63:32]; mul_b = MIX64[31:0];
            end
            S_B1:       mul_a = r_h[63:32];
            S_B2:       mul_a = r_w.data_word[31:0];
            S_B3, S_B6: mul_a = kmix;
            S_B4:       mul_a = r_h[31:0];
            S_B5:       mul_a = r_w.data_word[63:32];
            S_BT:       mul_a = r_h[31:0] ^ tail32;
            S_FIN:      mul_a = r_h[63:32] ^ (r_h[31:0] >> 18);
            S_F2:       mul_a = r_h[31:0] ^ (r_h[63:32] >> 22);
            S_F3:       mul_a = r_h[63:32] ^ (r_h[31:0] >> 17);
            S_F4:       mul_a = r_h[31:0] ^ (r_h[63:32] >> 19);
            default: ;
        endcase
    end

    assign o_q_pop      = (r_st == S_IDLE) && i_q_valid;
    assign out_load     = (r_st == S_OUT) && (!r_ov || i_ready);
    assign o_valid      = r_ov;
    assign o_hash_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ret <= S_IDLE; r_in_key <= 1'b0; r_ov <= 1'b0;
            r_h <= '0;
        end else begin
            r_ov <= out_load || (r_ov && !i_ready);
            if (out_load) r_out <= r_h;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_w <= i_q_word; r_b <= i_variant; r_in_key <= 1'b1;
                    r_st <= r_in_key ? S_BLK : S_INIT;
                end
                S_INIT: begin
                    if (r_b) begin
                        r_h <= {i_seed[31:0] ^ {1'b0, r_w.key_length}, i_seed[63:32]};
                        r_st <= S_BLK;
                    end else begin
                        r_mx <= {33'd0, r_w.key_length};
                        r_ret <= S_SEEDX; r_st <= S_M0;
                    end
                end
                S_SEEDX: begin
                    r_h <= i_seed ^ r_mp; r_st <= S_BLK;
                end
                S_BLK: begin
                    if (r_w.nbytes == 4'd0) r_st <= S_FIN;
                    else if (r_b) r_st <= (r_w.nbytes >= 4'd4) ? S_B1 : S_BT;
                    else if (r_w.nbytes == 4'd8) begin
                        r_mx <= r_w.data_word; r_ret <= S_A_K1; r_st <= S_M0;
                    end else begin
                        r_mx <= r_h ^ (r_w.data_word & low_mask);
                        r_ret <= S_A_H; r_st <= S_M0;
                    end
                end
                S_A_K1: begin
                    r_mx <= r_mp ^ (r_mp >> 47); r_ret <= S_A_K2; r_st <= S_M0;
                end
                S_A_K2: begin
                    r_mx <= r_h ^ r_mp; r_ret <= S_A_H; r_st <= S_M0;
                end
                S_A_H: begin
                    r_h <= r_mp; r_st <= S_FIN;
                end
                S_A_F2: begin
                    r_h <= r_mp ^ (r_mp >> 47); r_st <= S_OUT;
                end
                S_B1: begin
                    r_h[63:32] <= mul_y[31:0]; r_st <= S_B2;
                end
                S_B2: begin
                    r_k <= mul_y[31:0]; r_st <= S_B3;
                end
                S_B3: begin
                    r_h[63:32] <= r_h[63:32] ^ mul_y[31:0];
                    if (r_w.nbytes == 4'd8) r_st <= S_B4;
                    else if (r_w.nbytes == 4'd4) r_st <= S_FIN;
                    else r_st <= S_BT;
                end
                S_B4: begin
                    r_h[31:0] <= mul_y[31:0]; r_st <= S_B5;
                end
                S_B5: begin
                    r_k <= mul_y[31:0]; r_st <= S_B6;
                end
                S_B6: begin
                    r_h[31:0] <= r_h[31:0] ^ mul_y[31:0]; r_st <= S_FIN;
                end
                S_BT: begin
                    r_h[31:0] <= mul_y[31:0]; r_st <= S_FIN;
                end
                S_FIN: begin
                    if (!r_w.last) r_st <= S_IDLE;
                    else begin
                        r_in_key <= 1'b0;
                        if (r_b) begin
                            r_h[63:32] <= mul_y[31:0]; r_st <= S_F2;
                        end else begin
                            r_mx <= r_h ^ (r_h >> 47); r_ret <= S_A_F2; r_st <= S_M0;
                        end
                    end
                end
                S_F2: begin
                    r_h[31:0] <= mul_y[31:0]; r_st <= S_F3;
                end
                S_F3: begin
                    r_h[63:32] <= mul_y[31:0]; r_st <= S_F4;
                end
                S_F4: begin
                    r_h[31:0] <= mul_y[31:0]; r_st <= S_OUT;
                end
                S_M0: begin
                    r_mp <= mul_y; r_st <= S_M1;
                end
                S_M1: begin
                    r_mp[63:32] <= r_mp[63:32] + mul_y[31:0]; r_st <= S_M2;
                end
                S_M2: begin
                    r_mp[63:32] <= r_mp[63:32] + mul_y[31:0]; r_st <= r_ret;
                end
                S_OUT: if (out_load) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "murmur2_64_hash_assert.svh"
    `M2H_ASSERT(a_pop_idle, i_clk, i_rst_n, o_q_pop |-> r_st == S_IDLE)
    `M2H_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_hash_value))
    `M2H_ASSERT(a_out_last, i_clk, i_rst_n, (r_st == S_OUT) |-> r_w.last)
endmodule

>>> rtl/core/murmur2_64_hash.sv
// Top level of the streaming murmur2 64-bit hash engine.
// Each word passes from the two-entry queue into the m2h_back state sequence;
//   64A builds each 64-bit multiply in S_M0..S_M2, 64B does one 32-bit lane multiply per state.
// Words are hashed one at a time (a 64A first-and-last word takes longest), paced
//   by the single shared 32x32 multiplier; a two-word queue decouples the input.
// Reset (i_rst_n low, synchronous): seed and variant clear to 0, no key open.
module murmur2_64_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic [30:0] i_key_length,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_value
);
    import m2h_pkg::*;

    logic [63:0] r_seed;
    logic        r_variant;
    logic        q_valid, q_pop;
    t_word       q_word;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0; r_variant <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_seed <= i_cfg_data;
            else r_variant <= i_cfg_data[0];
        end
    end

    m2h_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_word, .i_valid_bytes,
        .i_key_length, .i_last, .o_q_valid(q_valid), .o_q_word(q_word), .i_q_pop(q_pop)
    );

    m2h_back u_back (
        .i_clk, .i_rst_n, .i_seed(r_seed), .i_variant(r_variant),
        .i_q_valid(q_valid), .i_q_word(q_word), .o_q_pop(q_pop),
        .o_valid, .i_ready, .o_hash_value
    );
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the streaming murmur2 64-bit hash engine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import m2h_pkg::*;

    localparam logic REG_SEED    = 1'b0;
    localparam logic REG_VARIANT = 1'b1;
    localparam int   DRAIN_CYCLES = 100;

    // Hash predictor and queue of expected hashes.
    class hash_scoreboard;
        logic [63:0] seed_reg;
        logic        variant_reg;
        logic [63:0] acc;
        bit          key_open;
        logic [63:0] pending_hashes[$];
        int          errors;

        function void clear();
            seed_reg = '0;
            variant_reg = 1'b0;
            acc = '0;
            key_open = 0;
            errors = 0;
        endfunction

        function logic [31:0] scramble32(logic [31:0] k);
            k = k * MIX32;
            k = k ^ (k >> 24);
            return k * MIX32;
        endfunction

        function logic [63:0] scramble64(logic [63:0] k);
            k = k * MIX64;
            k = k ^ (k >> 47);
            return k * MIX64;
        endfunction

        function logic [63:0] keep_bytes(logic [63:0] w, int n);
            if (n >= 8) return w;
            return w & ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        // Fold one accepted word into the running hash; queue a hash on last.
        function void note_word(logic [63:0] w, logic [3:0] vb, logic [30:0] len,
                                logic is_last);
            int n;
            int rest;
            logic [63:0] h;
            logic [63:0] tailsrc;
            logic [31:0] h1;
            logic [31:0] h2;
            n = (vb > 8) ? 8 : int'(vb);
            if (!is_last) n = 8;
            if (!key_open) begin
                if (variant_reg)
                    acc = {seed_reg[31:0] ^ {1'b0, len}, seed_reg[63:32]};
                else
                    acc = seed_reg ^ ({33'd0, len} * MIX64);
                key_open = 1;
            end
            if (!variant_reg) begin
                h = acc;
                if (n == 8) begin
                    h = (h ^ scramble64(w)) * MIX64;
                end else if (n > 0) begin
                    h = (h ^ keep_bytes(w, n)) * MIX64;
                end
                if (is_last) begin
                    h = h ^ (h >> 47);
                    h = h * MIX64;
                    h = h ^ (h >> 47);
                end
                acc = h;
            end else begin
                h1 = acc[63:32];
                h2 = acc[31:0];
                rest = n;
                tailsrc = w;
                if (rest >= 4) begin
                    h1 = h1 * MIX32;
                    h1 = h1 ^ scramble32(w[31:0]);
                    rest -= 4;
                    tailsrc = w >> 32;
                end
                if (rest == 4) begin
                    h2 = h2 * MIX32;
                    h2 = h2 ^ scramble32(w[63:32]);
                end else if (rest > 0) begin
                    h2 = (h2 ^ 32'(keep_bytes(tailsrc, rest))) * MIX32;
                end
                if (is_last) begin
                    h1 = (h1 ^ (h2 >> 18)) * MIX32;
                    h2 = (h2 ^ (h1 >> 22)) * MIX32;
                    h1 = (h1 ^ (h2 >> 17)) * MIX32;
                    h2 = (h2 ^ (h1 >> 19)) * MIX32;
                end
                acc = {h1, h2};
            end
            if (is_last) begin
                pending_hashes.push_back(acc);
                key_open = 0;
            end
        endfunction

        function void check_hash(logic [63:0] got);
            logic [63:0] want;
            if (pending_hashes.size() == 0) begin
                $error("hash_value: unexpected word, actual %h", got);
                errors++;
                return;
            end
            want = pending_hashes.pop_front();
            if (got !== want) begin
                $error("hash_value: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_data_word;
    logic [3:0]  i_valid_bytes;
    logic [30:0] i_key_length;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_hash_value;

    hash_scoreboard sb;
    bit  rx_hold;      // hold the receiver off for a long stretch
    bit  rx_stop_idle; // run the receiver without stalls

    murmur2_64_hash dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("murmur2_64_hash regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Check every accepted hash word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_hash(o_hash_value);
    end

    // Receiver: random ready, with a long hold when asked.
    initial begin
        int g;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
            g = rx_stop_idle ? 0 : gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic write_reg(logic idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SEED) sb.seed_reg = val;
        else sb.variant_reg = val[0];
        @(posedge i_clk);
    endtask

    // Offer one word and advance once it is taken; optional idle gap first.
    task automatic send_word(logic [63:0] w, logic [3:0] vb, logic [30:0] len,
                             logic is_last, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_word <= w;
        i_valid_bytes <= vb;
        i_key_length <= len;
        i_last <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(w, vb, len, is_last);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait out every pending hash, then the pipeline tail.
    task automatic drain();
        go_idle();
        while (sb.pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Send a well-formed key of the given byte length.
    task automatic send_key(int nbytes, bit idle);
        int words;
        int rem;
        words = (nbytes + 7) / 8;
        if (words == 0) words = 1;
        for (int i = 0; i < words; i++) begin
            rem = nbytes - 8 * i;
            if (i == words - 1)
                send_word(rand64(), rem[3:0], nbytes[30:0], 1'b1, idle);
            else
                send_word(rand64(), 4'd8, nbytes[30:0], 1'b0, idle);
        end
    endtask

    initial begin
        int lens;
        int count;
        sb = new();
        sb.clear();
        rx_hold = 0;
        rx_stop_idle = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_SEED;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data_word = '0;
        i_valid_bytes = '0;
        i_key_length = '0;
        i_last = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, then extremes and every tail length.
        send_word(64'd0, 4'd0, 31'd0, 1'b1, 0);
        send_word('1, 4'd8, '1, 1'b1, 0);
        for (int v = 0; v < 2; v++) begin
            drain();
            write_reg(REG_VARIANT, 64'(v));
            write_reg(REG_SEED, v ? 64'd0 : '1);
            for (int n = 0; n <= 15; n++)
                send_word('1, n[3:0], 31'(n), 1'b1, 0);
            // Non-last word ignores its byte count.
            send_word(64'h0123456789abcdef, 4'd0, 31'd12, 1'b0, 0);
            send_word(64'hfedcba9876543210, 4'd4, 31'd12, 1'b1, 0);
        end
        // Variant switched in the middle of a key.
        drain();
        send_word(rand64(), 4'd8, 31'd20, 1'b0, 0);
        drain();
        write_reg(REG_VARIANT, 64'd0);
        send_word(rand64(), 4'd8, 31'd20, 1'b0, 0);
        drain();
        write_reg(REG_VARIANT, 64'd1);
        send_word(rand64(), 4'd4, 31'd20, 1'b1, 0);

        // Long receiver hold-off while the sender keeps pushing.
        rx_hold = 1;
        for (int i = 0; i < 20; i++) send_key(8, 0);
        drain();

        // Random phases across seeds and variants.
        count = 0;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            write_reg(REG_SEED, phase == 0 ? 64'd0 : (phase == 1 ? '1 : rand64()));
            write_reg(REG_VARIANT, 64'($urandom_range(0, 1)));
            rx_stop_idle = (phase == 3);
            repeat (90) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: mismatched length and stray byte counts.
                    send_word(rand64(), 4'($urandom()), 31'($urandom()),
                              1'($urandom()), phase != 3);
                    count++;
                end else begin
                    lens = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 80)
                                                         : $urandom_range(0, 24);
                    send_key(lens, phase != 3);
                    count += (lens + 7) / 8 + (lens == 0);
                end
            end
            // Pause until all hashes are in before the next phase.
            drain();
        end
        rx_stop_idle = 0;
        // Close any key left open by noise.
        send_word(rand64(), 4'd3, 31'd3, 1'b1, 0);
        drain();
        if (sb.errors == 0 && sb.pending_hashes.size() == 0) begin
            $display("murmur2_64_hash regression: pass");
        end else begin
            $display("murmur2_64_hash regression: fail");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/m2h_pkg.sv
rtl/core/m2h_front.sv
rtl/core/m2h_back.sv
rtl/core/murmur2_64_hash.sv
sim/testbench.sv
